>>> hdl/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants of the ultrasonic ranging block: phase codes,
// register map, configuration and result bundles, distance scaling.
// ----------------------------------------------------------------------------
package urm_pkg;

   // register map
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;
   localparam logic [1:0] REG_TRIGGER_HIGH = 2'd0;
   localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_GAP          = 2'd2;
   localparam logic [1:0] REG_MAX_DISTANCE = 2'd3;

   localparam logic [7:0]  RST_TRIGGER_HIGH = 8'd10;
   localparam logic [15:0] RST_ECHO_TIMEOUT = 16'd30000;
   localparam logic [16:0] RST_GAP          = 17'd35000;
   localparam logic [15:0] RST_MAX_DISTANCE = 16'd50000;

   // timing and scaling
   localparam int unsigned CNT_W          = 17;
   localparam int unsigned DIST_W         = 16;
   localparam logic [CNT_W:0] TRIG_LOW_TICKS = 18'd2;
   // round(up) of 343/200 * 2^24: exact floor for every 16 bit duration
   localparam int unsigned MULT_W         = 25;
   localparam int unsigned DIST_SHIFT     = 24;
   localparam logic [MULT_W-1:0] DIST_MULT = 25'd28772926;
   localparam logic [DIST_W-1:0] DIST_MAX  = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIG_LOW  = 3'd1,
      PH_TRIG_HIGH = 3'd2,
      PH_WAIT_RISE = 3'd3,
      PH_MEASURE   = 3'd4,
      PH_GAP       = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]  trigger_high_ticks;
      logic [15:0] echo_timeout_ticks;
      logic [16:0] gap_ticks;
      logic [15:0] max_distance_centi_cm;
   } cfg_type;

   typedef struct packed {
      logic              trigger_level;
      logic              done_res;
      logic [DIST_W-1:0] distance_centi_cm;
      logic              no_valid;
      logic [1:0]        valid_readings;
   } result_type;

endpackage

>>> hdl/urm_csr.sv
// ----------------------------------------------------------------------------
// urm_csr
// APB register bank holding the ranging configuration.
// ----------------------------------------------------------------------------
module urm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [urm_pkg::ADDR_W-1:0]  paddr,
   input  logic [urm_pkg::DATA_W-1:0]  pwdata,
   output logic [urm_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output urm_pkg::cfg_type            cfg
);

   urm_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_high_ticks    <= urm_pkg::RST_TRIGGER_HIGH;
         cfg_ff.echo_timeout_ticks    <= urm_pkg::RST_ECHO_TIMEOUT;
         cfg_ff.gap_ticks             <= urm_pkg::RST_GAP;
         cfg_ff.max_distance_centi_cm <= urm_pkg::RST_MAX_DISTANCE;
      end else if (wr_en) begin
         case (reg_sel)
            urm_pkg::REG_TRIGGER_HIGH: cfg_ff.trigger_high_ticks <= pwdata[7:0];
            urm_pkg::REG_ECHO_TIMEOUT: cfg_ff.echo_timeout_ticks <= pwdata[15:0];
            urm_pkg::REG_GAP:          cfg_ff.gap_ticks <= pwdata[16:0];
            urm_pkg::REG_MAX_DISTANCE: cfg_ff.max_distance_centi_cm <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         urm_pkg::REG_TRIGGER_HIGH: prdata = 32'(cfg_ff.trigger_high_ticks);
         urm_pkg::REG_ECHO_TIMEOUT: prdata = 32'(cfg_ff.echo_timeout_ticks);
         urm_pkg::REG_GAP:          prdata = 32'(cfg_ff.gap_ticks);
         urm_pkg::REG_MAX_DISTANCE: prdata = 32'(cfg_ff.max_distance_centi_cm);
         default:                   prdata = '0;
      endcase
   end

endmodule

>>> hdl/urm_core.sv
// ----------------------------------------------------------------------------
// urm_core
// Tick-driven ranging sequencer: trigger pulse, echo timing, distance
// scaling, kept-reading store and median pick. One tick per step.
// ----------------------------------------------------------------------------
module urm_core #(
   parameter int READINGS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  urm_pkg::cfg_type    cfg,
   input  logic                step_en,
   input  logic                start_req,
   input  logic                echo_level,
   output urm_pkg::result_type result
);

   localparam int unsigned CW   = urm_pkg::CNT_W;
   localparam int unsigned DW   = urm_pkg::DIST_W;
   localparam int unsigned PW   = DW + urm_pkg::MULT_W;
   localparam int unsigned SH   = urm_pkg::DIST_SHIFT;

   urm_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [1:0]         idx_ff, idx_in;
   logic [1:0]         kept_cnt_ff, kept_cnt_in;
   logic [DW-1:0]      kept_ff [READINGS];

   logic [CW:0]        cnt_inc;
   logic [7:0]         th;
   logic [CW-1:0]      gp;
   logic [CW-1:0]      timeout;
   logic [1:0]         idx_next;
   logic [PW-1:0]      prod;
   logic [DW:0]        dist_raw;
   logic [DW-1:0]      dist_sat;
   logic               keep_ok;
   logic               keep_en;
   logic               finish;

   logic [DW-1:0]      view [3];
   logic [DW-1:0]      lo, hi, mid, median;

   // saturate zero trigger-high and gap settings to one
   assign th       = (cfg.trigger_high_ticks == '0) ? 8'd1 : cfg.trigger_high_ticks;
   assign gp       = (cfg.gap_ticks == '0) ? 17'd1 : cfg.gap_ticks;
   assign timeout  = CW'(cfg.echo_timeout_ticks);
   assign cnt_inc  = {1'b0, cnt_ff} + 18'd1;
   assign idx_next = idx_ff + 2'd1;

   // duration * 343 / 200 by reciprocal multiply
   assign prod     = PW'(cnt_ff[DW-1:0]) * PW'(urm_pkg::DIST_MULT);
   assign dist_raw = prod[PW-1:SH];
   assign dist_sat = dist_raw[DW] ? urm_pkg::DIST_MAX : dist_raw[DW-1:0];
   assign keep_ok  = (dist_sat != '0) && (dist_sat < cfg.max_distance_centi_cm)
                     && (kept_cnt_ff < 2'(READINGS));

   // next state
   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      kept_cnt_in = kept_cnt_ff;
      keep_en     = 1'b0;
      finish      = 1'b0;
      case (phase_ff)
         urm_pkg::PH_TRIG_LOW: begin
            cnt_in = cnt_inc[CW-1:0];
            if (cnt_inc >= urm_pkg::TRIG_LOW_TICKS) begin
               phase_in = urm_pkg::PH_TRIG_HIGH;
               cnt_in   = '0;
            end
         end
         urm_pkg::PH_TRIG_HIGH: begin
            cnt_in = cnt_inc[CW-1:0];
            if (cnt_inc >= (CW+1)'(th)) begin
               phase_in = urm_pkg::PH_WAIT_RISE;
               cnt_in   = '0;
            end
         end
         urm_pkg::PH_WAIT_RISE: begin
            if (echo_level && (cnt_ff < timeout)) begin
               phase_in = urm_pkg::PH_MEASURE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc[CW-1:0];
               if (cnt_inc >= {1'b0, timeout}) begin
                  phase_in = urm_pkg::PH_GAP;
                  cnt_in   = '0;
               end
            end
         end
         urm_pkg::PH_MEASURE: begin
            if (!echo_level) begin
               keep_en = keep_ok;
               if (keep_ok) begin
                  kept_cnt_in = kept_cnt_ff + 2'd1;
               end
               phase_in = urm_pkg::PH_GAP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc[CW-1:0];
               if (cnt_inc >= {1'b0, timeout}) begin
                  phase_in = urm_pkg::PH_GAP;
                  cnt_in   = '0;
               end
            end
         end
         urm_pkg::PH_GAP: begin
            cnt_in = cnt_inc[CW-1:0];
            if (cnt_inc >= {1'b0, gp}) begin
               cnt_in = '0;
               if ((idx_next >= 2'(READINGS)) || (idx_next == 2'd0)) begin
                  finish   = 1'b1;
                  phase_in = urm_pkg::PH_IDLE;
                  idx_in   = 2'd0;
               end else begin
                  phase_in = urm_pkg::PH_TRIG_LOW;
                  idx_in   = idx_next;
               end
            end
         end
         default: begin
            phase_in = urm_pkg::PH_IDLE;
            if (start_req) begin
               phase_in    = urm_pkg::PH_TRIG_LOW;
               cnt_in      = '0;
               idx_in      = 2'd0;
               kept_cnt_in = 2'd0;
            end
         end
      endcase
   end

   // entries past the store depth read as zero and are never selected
   for (genvar g = 0; g < 3; g++) begin : g_view
      if (g < READINGS) begin : g_live
         assign view[g] = kept_ff[g];
      end else begin : g_none
         assign view[g] = '0;
      end
   end

   assign lo  = (view[0] < view[1]) ? view[0] : view[1];
   assign hi  = (view[0] < view[1]) ? view[1] : view[0];
   assign mid = (hi < view[2]) ? hi : view[2];

   always_comb begin
      case (kept_cnt_ff)
         2'd1:    median = view[0];
         2'd2:    median = hi;
         default: median = (lo > mid) ? lo : mid;
      endcase
   end

   // outputs
   always_comb begin
      result                   = '0;
      result.trigger_level     = (phase_ff == urm_pkg::PH_TRIG_HIGH);
      result.done_res          = finish;
      if (finish) begin
         result.valid_readings = kept_cnt_ff;
         result.no_valid       = (kept_cnt_ff == 2'd0);
         if (kept_cnt_ff != 2'd0) begin
            result.distance_centi_cm = median;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= urm_pkg::PH_IDLE;
         cnt_ff      <= '0;
         idx_ff      <= 2'd0;
         kept_cnt_ff <= 2'd0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
         kept_cnt_ff <= kept_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < READINGS; i++) begin
         if (step_en && keep_en && (kept_cnt_ff == 2'(i))) begin
            kept_ff[i] <= dist_sat;
         end
      end
   end

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_cnt_ff <= 2'(READINGS))
      else $error("kept reading count exceeds store depth");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff < 2'(READINGS))
      else $error("reading index out of range");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done_res |=> phase_ff == urm_pkg::PH_IDLE && idx_ff == 2'd0)
      else $error("measurement did not return to idle after result");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && start_req && phase_ff == urm_pkg::PH_IDLE
      |=> phase_ff == urm_pkg::PH_TRIG_LOW && kept_cnt_ff == 2'd0)
      else $error("start did not begin a fresh measurement");

endmodule

>>> hdl/ultrasonic_ranging_median.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_median
// Ultrasonic echo ranging controller, median of up to three readings,
// stepped by one microsecond tick per input item.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    start_req, echo_level
//   rsp      out        rsp_valid/ready    trigger_level, done_res,
//                                          distance_centi_cm, no_valid,
//                                          valid_readings
//   csr      in/out     APB psel/penable   four config registers at 4*i
//
// Each item's result sits in the output register the cycle after the item
// is accepted, and a new item is taken every cycle while req_ready is high.
// The result register is the only stage; req_ready drops only while a
// result waits and rsp_ready is low.
// Reset is synchronous and returns the sequencer to idle with default config.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_median #(
   parameter int READINGS = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_start_req,
   input  logic                        req_echo_level,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_trigger_level,
   output logic                        rsp_done_res,
   output logic [15:0]                 rsp_distance_centi_cm,
   output logic                        rsp_no_valid,
   output logic [1:0]                  rsp_valid_readings,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [urm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [urm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [urm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   urm_pkg::cfg_type    cfg;
   urm_pkg::result_type result;
   urm_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;
   logic                step_en;

   urm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   urm_core #(
      .READINGS (READINGS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_en    (step_en),
      .start_req  (req_start_req),
      .echo_level (req_echo_level),
      .result     (result)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step_en   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // load a new result only when the old one has left
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = rsp_ff.trigger_level;
   assign rsp_done_res          = rsp_ff.done_res;
   assign rsp_distance_centi_cm = rsp_ff.distance_centi_cm;
   assign rsp_no_valid          = rsp_ff.no_valid;
   assign rsp_valid_readings    = rsp_ff.valid_readings;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(step_en && rsp_valid_ff && !rsp_ready))
      else $error("item taken while pending result was stalled");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_no_valid && rsp_valid_readings == 2'd0
      && rsp_distance_centi_cm == 16'd0)
      else $error("result fields set without done");

   a_none_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_no_valid == (rsp_valid_readings == 2'd0))
      else $error("no_valid disagrees with kept count");

endmodule

>>> test/ranging_checker.sv
// ----------------------------------------------------------------------------
// ranging_checker
// Watches the tick, result and register ports of the ranging block. Keeps its
// own copy of the ranging sequencer and register file, works out the result
// of every accepted tick and compares each accepted result, field by field,
// with the oldest one outstanding.
// ----------------------------------------------------------------------------
module ranging_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_start_req,
   input  logic                        req_echo_level,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_trigger_level,
   input  logic                        rsp_done_res,
   input  logic [15:0]                 rsp_distance_centi_cm,
   input  logic                        rsp_no_valid,
   input  logic [1:0]                  rsp_valid_readings,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic                        csr_pready,
   input  logic [urm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [urm_pkg::DATA_W-1:0]  csr_pwdata,
   output int                          fail_count,
   output int                          due_count
);

   localparam int unsigned READINGS_PER_RUN = 3;
   localparam int unsigned SPEED_NUM        = 343;
   localparam int unsigned SPEED_DEN        = 200;

   urm_pkg::cfg_type     cfg;
   urm_pkg::phase_type   phase;
   logic [16:0]          ticks;
   logic [1:0]           reading_no;
   logic [1:0]           kept_no;
   logic [15:0]          kept_dist [3];
   urm_pkg::result_type  due_outputs [$];
   int                   results_seen;

   task automatic flag_mismatch(input string what, input int unsigned got_v,
                                input int unsigned want_v);
      fail_count++;
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got_v, want_v);
   endtask

   function automatic logic [15:0] echo_to_distance(input logic [16:0] dur);
      logic [31:0] scaled;
      scaled = ({15'd0, dur} * SPEED_NUM) / SPEED_DEN;
      if (scaled > {16'd0, urm_pkg::DIST_MAX}) begin
         return urm_pkg::DIST_MAX;
      end
      return scaled[15:0];
   endfunction

   function automatic logic [15:0] median_kept();
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      logic [15:0] t;
      a = kept_dist[0];
      b = kept_dist[1];
      c = kept_dist[2];
      if (kept_no == 2'd1) begin
         return a;
      end
      if (kept_no == 2'd2) begin
         return (a > b) ? a : b;
      end
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
      return b;
   endfunction

   task automatic close_reading(input bit ok, input logic [16:0] dur);
      logic [15:0] d;
      if (ok) begin
         d = echo_to_distance(dur);
         if (d > 0 && d < cfg.max_distance_centi_cm && kept_no < 2'd3) begin
            kept_dist[kept_no] = d;
            kept_no++;
         end
      end
      phase = urm_pkg::PH_GAP;
      ticks = '0;
   endtask

   task automatic predict_tick(input logic start, input logic echo,
                               output urm_pkg::result_type r);
      logic [16:0] high_len;
      logic [16:0] gap_len;
      high_len = (cfg.trigger_high_ticks == 0) ? 17'd1 : {9'd0, cfg.trigger_high_ticks};
      gap_len  = (cfg.gap_ticks == 0) ? 17'd1 : cfg.gap_ticks;
      r = '0;
      case (phase)
         urm_pkg::PH_TRIG_LOW: begin
            ticks++;
            if (ticks >= urm_pkg::TRIG_LOW_TICKS) begin
               phase = urm_pkg::PH_TRIG_HIGH;
               ticks = '0;
            end
         end
         urm_pkg::PH_TRIG_HIGH: begin
            r.trigger_level = 1'b1;
            ticks++;
            if (ticks >= high_len) begin
               phase = urm_pkg::PH_WAIT_RISE;
               ticks = '0;
            end
         end
         urm_pkg::PH_WAIT_RISE: begin
            if (echo && ticks < cfg.echo_timeout_ticks) begin
               phase = urm_pkg::PH_MEASURE;
               ticks = '0;
            end else begin
               ticks++;
               if (ticks >= cfg.echo_timeout_ticks) close_reading(1'b0, '0);
            end
         end
         urm_pkg::PH_MEASURE: begin
            if (!echo) begin
               close_reading(1'b1, ticks);
            end else begin
               ticks++;
               if (ticks >= cfg.echo_timeout_ticks) close_reading(1'b0, '0);
            end
         end
         urm_pkg::PH_GAP: begin
            ticks++;
            if (ticks >= gap_len) begin
               ticks = '0;
               reading_no++;
               if (reading_no >= READINGS_PER_RUN || reading_no == 2'd0) begin
                  r.done_res       = 1'b1;
                  r.valid_readings = kept_no;
                  if (kept_no == 2'd0) r.no_valid = 1'b1;
                  else r.distance_centi_cm = median_kept();
                  phase      = urm_pkg::PH_IDLE;
                  reading_no = '0;
               end else begin
                  phase = urm_pkg::PH_TRIG_LOW;
               end
            end
         end
         default: begin
            phase = urm_pkg::PH_IDLE;
            if (start) begin
               phase      = urm_pkg::PH_TRIG_LOW;
               ticks      = '0;
               reading_no = '0;
               kept_no    = '0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : track
      urm_pkg::result_type want;
      urm_pkg::result_type next_out;
      if (reset) begin
         cfg.trigger_high_ticks    = urm_pkg::RST_TRIGGER_HIGH;
         cfg.echo_timeout_ticks    = urm_pkg::RST_ECHO_TIMEOUT;
         cfg.gap_ticks             = urm_pkg::RST_GAP;
         cfg.max_distance_centi_cm = urm_pkg::RST_MAX_DISTANCE;
         phase      = urm_pkg::PH_IDLE;
         ticks      = '0;
         reading_no = '0;
         kept_no    = '0;
         for (int i = 0; i < 3; i++) kept_dist[i] = '0;
         due_outputs.delete();
      end else begin
         // retire the result first: it belongs to an earlier item
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (due_outputs.size() == 0) begin
               flag_mismatch("result with no item outstanding", 0, 0);
            end else begin
               want = due_outputs.pop_front();
               if (rsp_trigger_level !== want.trigger_level)
                  flag_mismatch("trigger_level", 32'(rsp_trigger_level),
                                32'(want.trigger_level));
               if (rsp_done_res !== want.done_res)
                  flag_mismatch("done_res", 32'(rsp_done_res), 32'(want.done_res));
               if (rsp_distance_centi_cm !== want.distance_centi_cm)
                  flag_mismatch("distance_centi_cm", 32'(rsp_distance_centi_cm),
                                32'(want.distance_centi_cm));
               if (rsp_no_valid !== want.no_valid)
                  flag_mismatch("no_valid", 32'(rsp_no_valid), 32'(want.no_valid));
               if (rsp_valid_readings !== want.valid_readings)
                  flag_mismatch("valid_readings", 32'(rsp_valid_readings),
                                32'(want.valid_readings));
            end
         end
         if (req_valid && req_ready) begin
            predict_tick(req_start_req, req_echo_level, next_out);
            due_outputs.push_back(next_out);
         end
         // a register write lands after this edge's item
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[urm_pkg::ADDR_W-1:2])
               urm_pkg::REG_TRIGGER_HIGH:
                  cfg.trigger_high_ticks    = csr_pwdata[7:0];
               urm_pkg::REG_ECHO_TIMEOUT:
                  cfg.echo_timeout_ticks    = csr_pwdata[15:0];
               urm_pkg::REG_GAP:
                  cfg.gap_ticks             = csr_pwdata[16:0];
               urm_pkg::REG_MAX_DISTANCE:
                  cfg.max_distance_centi_cm = csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
      due_count = due_outputs.size();
   end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the ranging block with microsecond ticks: a start under reset
// settings, a short hand-made measurement covering echo, busy-start and
// timeout cases, a short stretch at the largest register values, then many
// short runs under random settings and random echo pulse trains. Sender and
// receiver idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_RUNS  = 24;
   localparam int TICKS_PER_RUN = 70;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_start_req;
   logic                         req_echo_level;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_trigger_level;
   logic                         rsp_done_res;
   logic [15:0]                  rsp_distance_centi_cm;
   logic                         rsp_no_valid;
   logic [1:0]                   rsp_valid_readings;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [urm_pkg::ADDR_W-1:0]   csr_paddr;
   logic [urm_pkg::DATA_W-1:0]   csr_pwdata;
   logic [urm_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   int  fail_count;
   int  due_count;
   int  cycle_count = 0;
   bit  pressure_req = 1'b0;

   // echo pulse train and burst state
   logic echo_now  = 1'b0;
   int   seg_left  = 0;
   int   hi_min    = 1;
   int   hi_max    = 1;
   int   lo_min    = 1;
   int   lo_max    = 1;
   int   start_pct = 0;
   int   burst_left = 0;

   ultrasonic_ranging_median u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_start_req         (req_start_req),
      .req_echo_level        (req_echo_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_done_res          (rsp_done_res),
      .rsp_distance_centi_cm (rsp_distance_centi_cm),
      .rsp_no_valid          (rsp_no_valid),
      .rsp_valid_readings    (rsp_valid_readings),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   ranging_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_start_req         (req_start_req),
      .req_echo_level        (req_echo_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_done_res          (rsp_done_res),
      .rsp_distance_centi_cm (rsp_distance_centi_cm),
      .rsp_no_valid          (rsp_no_valid),
      .rsp_valid_readings    (rsp_valid_readings),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_pready            (csr_pready),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .fail_count            (fail_count),
      .due_count             (due_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver: short stalls, ready stretches, and one long hold-off on request
   initial begin : receiver
      int  stall_left;
      int  run_left;
      bit  held;
      stall_left = 0;
      run_left   = 0;
      held       = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_req && !held) begin
            held       = 1'b1;
            stall_left = 299;
            run_left   = 0;
            rsp_ready  <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_ready <= 1'b1;
            run_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(3, 0) == 0) begin
               run_left = $urandom_range(120, 20);
            end else begin
               stall_left = $urandom_range(3, 0);
               run_left   = $urandom_range(6, 0);
            end
         end
      end
   end

   task automatic send_tick(input logic start, input logic echo);
      int gap_len;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(400, 100)
                                                  : $urandom_range(24, 1);
         gap_len = $urandom_range(4, 0);
         repeat (gap_len) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_start_req  <= start;
      req_echo_level <= echo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic step_echo(output logic echo);
      if (seg_left == 0) begin
         echo_now = !echo_now;
         seg_left = echo_now ? $urandom_range(hi_max, hi_min)
                             : $urandom_range(lo_max, lo_min);
      end
      seg_left--;
      echo = echo_now;
   endtask

   task automatic run_ticks(input int count);
      logic s;
      logic e;
      repeat (count) begin
         s = ($urandom_range(99, 0) < start_pct);
         step_echo(e);
         send_tick(s, e);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx,
                            input logic [urm_pkg::DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // drop valid and wait until every outstanding result has been checked
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      int p;
      logic [urm_pkg::DATA_W-1:0] v;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_req  = 1'b0;
      req_echo_level = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // start under reset settings: long trigger pulse, echo during rise wait
      for (k = 0; k < 40; k++) send_tick(k == 0, k >= 15 && k <= 20);

      // small settings, then flush the open measurement with quiet ticks
      quiesce();
      write_reg(urm_pkg::REG_TRIGGER_HIGH, 32'd1);
      write_reg(urm_pkg::REG_ECHO_TIMEOUT, 32'd3);
      write_reg(urm_pkg::REG_GAP,          32'd1);
      write_reg(urm_pkg::REG_MAX_DISTANCE, 32'd65535);
      for (k = 0; k < 30; k++) send_tick(1'b0, 1'b0);

      // hand-made run: echo during trigger, short echo kept, echo low on the
      // first fall sample, rise timeout, and starts while busy
      for (k = 0; k < 21; k++) begin
         send_tick(k == 0 || k == 5 || k == 9,
                   k == 2 || k == 4 || k == 5 || k == 11);
      end

      // largest settings: long trigger pulse and long echo segments
      quiesce();
      write_reg(urm_pkg::REG_TRIGGER_HIGH, 32'd255);
      write_reg(urm_pkg::REG_ECHO_TIMEOUT, 32'd65535);
      write_reg(urm_pkg::REG_GAP,          32'd131071);
      write_reg(urm_pkg::REG_MAX_DISTANCE, 32'd65535);
      hi_min    = 15000;
      hi_max    = 70000;
      lo_min    = 1;
      lo_max    = 70000;
      start_pct = 50;
      seg_left  = 0;
      run_ticks(300);

      // random settings, each run short; measurements carry across runs
      for (p = 0; p < RANDOM_RUNS; p++) begin
         quiesce();
         for (k = 0; k < 4; k++) begin
            if (p == 0 || $urandom_range(1, 0) == 1) begin
               case (k)
                  urm_pkg::REG_TRIGGER_HIGH: begin
                     case ($urandom_range(9, 0))
                        0:       v = 32'd0;
                        1:       v = 32'd255;
                        default: v = $urandom_range(4, 1);
                     endcase
                  end
                  urm_pkg::REG_ECHO_TIMEOUT: begin
                     case ($urandom_range(9, 0))
                        0:       v = 32'd0;
                        1:       v = 32'd1;
                        default: v = $urandom_range(24, 2);
                     endcase
                  end
                  urm_pkg::REG_GAP: begin
                     case ($urandom_range(9, 0))
                        0:       v = 32'd0;
                        1:       v = $urandom_range(40, 7);
                        default: v = $urandom_range(6, 1);
                     endcase
                  end
                  default: begin
                     case ($urandom_range(9, 0))
                        0:       v = 32'd0;
                        1:       v = 32'd65535;
                        2:       v = 32'd1;
                        default: v = $urandom_range(45, 2);
                     endcase
                  end
               endcase
               write_reg(k[1:0], v);
            end
         end
         hi_min    = 1;
         hi_max    = $urandom_range(24, 1);
         lo_min    = 1;
         lo_max    = $urandom_range(16, 1);
         start_pct = $urandom_range(60, 5);
         seg_left  = 0;
         // hold the receiver off while this run keeps offering items
         if (p == 2) pressure_req = 1'b1;
         run_ticks(TICKS_PER_RUN);
      end

      quiesce();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && due_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/urm_pkg.sv
hdl/urm_csr.sv
hdl/urm_core.sv
hdl/ultrasonic_ranging_median.sv
test/ranging_checker.sv
test/tb_top.sv
